### src/sha_pkg.sv
// Package: shared types, constants and functions of the SHA-256 stream hasher.
package sha_pkg;

    typedef struct packed {
        logic       fin;
        logic [7:0] data;
    } beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### src/sha_fifo.sv
// Module: short beat queue between the front end and the engine.
module sha_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  sha_pkg::beat_t in_beat,
    output logic           out_valid,
    input  logic           out_ready,
    output sha_pkg::beat_t out_beat
);

    sha_pkg::beat_t mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 3'd4);
    assign out_valid = (count_reg != 3'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_beat  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4) else $error("queue count out of range");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 3'd1))
        else $error("queue count missed a push");
    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 3'd0) |-> !pop) else $error("pop from empty queue");
`endif

endmodule

### src/sha_engine.sv
// Module: block buffer, padding, 64-round compression and digest output.
module sha_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           beat_valid,
    output logic           beat_ready,
    input  sha_pkg::beat_t beat,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    digest_word,
    output logic [2:0]     word_index,
    output logic           last_word
);

    sha_pkg::state_t state_reg, state_next;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [63:0] total_reg;
    logic [5:0]  rnd_reg;
    logic        final_reg;
    logic        extra_reg;
    logic [2:0]  idx_reg;
    logic [31:0] new_w;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] pad_word [16];
    logic        accept;

    assign beat_ready  = (state_reg == sha_pkg::ST_IDLE);
    assign accept      = beat_valid && beat_ready;
    assign out_valid   = (state_reg == sha_pkg::ST_EMIT);
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    always_comb
    begin
        s0    = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
                ^ (w_reg[14] >> 10);
        new_w = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7] + (sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
             ^ sha_pkg::rotr(v_reg[4], 25)) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + sha_pkg::round_k(rnd_reg) + w_reg[0];
        t2 = (sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
             ^ sha_pkg::rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // padding rewrite: bytes at/after fill position, all in extra block
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                logic [7:0] byt;
                logic [5:0] pos;
                pos = 6'(4 * i + b);
                byt = w_reg[i][31 - 8 * b -: 8];
                if (!extra_reg)
                begin
                    if (pos == fill_reg)
                    begin
                        byt = sha_pkg::PAD_BYTE;
                    end
                    else if (pos > fill_reg)
                    begin
                        byt = 8'h00;
                    end
                end
                else
                begin
                    byt = (pos == 6'd0 && fill_reg == 6'd0) ? sha_pkg::PAD_BYTE : 8'h00;
                end
                if (pos >= 6'(sha_pkg::LEN_POS) && (extra_reg || fill_reg < 6'd56))
                begin
                    byt = total_reg[63 - 8 * (32'(pos) - sha_pkg::LEN_POS) -: 8];
                end
                pad_word[i][31 - 8 * b -: 8] = byt;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (beat.fin)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                    else if (fill_reg == 6'd63)
                    begin
                        state_next = sha_pkg::ST_ROUND;
                    end
                end
            end
            sha_pkg::ST_PAD:   state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD:
            begin
                if (!final_reg)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
                else if (!extra_reg && fill_reg >= 6'd56)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_EMIT;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                if (out_ready && idx_reg == 3'd7)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default:           state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
            rnd_reg   <= 6'd0;
            final_reg <= 1'b0;
            extra_reg <= 1'b0;
            idx_reg   <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::INIT_HASH[255 - 32 * i -: 32];
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                sha_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (beat.fin)
                        begin
                            final_reg <= 1'b1;
                            extra_reg <= 1'b0;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + 6'd1;
                            final_reg <= 1'b0;
                            if (fill_reg == 6'd63)
                            begin
                                bits_reg <= bits_reg + 64'd512;
                                rnd_reg  <= 6'd0;
                            end
                        end
                    end
                end
                sha_pkg::ST_PAD:
                begin
                    rnd_reg <= 6'd0;
                end
                sha_pkg::ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                end
                sha_pkg::ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (final_reg && !extra_reg && fill_reg >= 6'd56)
                    begin
                        extra_reg <= 1'b1;
                    end
                end
                sha_pkg::ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            fill_reg  <= 6'd0;
                            bits_reg  <= 64'd0;
                            final_reg <= 1'b0;
                            extra_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha_pkg::INIT_HASH[255 - 32 * i -: 32];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath: buffer doubles as the schedule window
    always_ff @(posedge clk)
    begin
        if (state_reg == sha_pkg::ST_IDLE && accept)
        begin
            if (beat.fin)
            begin
                total_reg <= bits_reg + {55'd0, fill_reg, 3'd0};
            end
            else
            begin
                w_reg[fill_reg[5:2]][31 - 8 * fill_reg[1:0] -: 8] <= beat.data;
                if (fill_reg == 6'd63)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                end
            end
        end
        else if (state_reg == sha_pkg::ST_PAD)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= pad_word[i];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == sha_pkg::ST_ADD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
        else if (state_reg == sha_pkg::ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= new_w;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

`ifndef ASSERT_OFF
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(idx_reg)))
        else $error("digest word dropped while stalled");
    a_round_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ROUND && rnd_reg == 6'd63) |=> state_reg == sha_pkg::ST_ADD)
        else $error("round counter did not end compression");
    a_emit_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> final_reg) else $error("digest shown without finish");
`endif

endmodule

### src/sha256_stream_hasher.sv
// SHA-256 stream hasher: byte beats in, eight digest word beats out per message.
//
// Input channel (valid/ready): operation 0 absorbs message_byte, operation 1
// finishes the message. Output channel (valid/ready): eight beats per finish,
// digest_word big-endian, word_index 0..7, last_word on the eighth.
// A four-beat queue decouples the input from the engine.
// The engine takes a byte while idle; the 64th byte of a block starts a
// compression (working variables loaded with that byte, 64 rounds through one
// round unit, an add), during which the queue keeps taking beats until it fills.
// A finish runs a padding load, 64 rounds and an add, twice when more than 55
// bytes are buffered, then eight output beats, one per cycle while ready is high.
// A stall on the output holds the current word; the input backs up once the
// queue is full. Reset loads the initial hash, clears the counts and empties
// the queue; the block then accepts at once.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  message_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha_pkg::beat_t in_beat;
    sha_pkg::beat_t q_beat;
    logic           q_valid;
    logic           q_ready;

    assign in_beat.fin  = operation;
    assign in_beat.data = message_byte;

    sha_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_beat  (q_beat)
    );

    sha_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat_valid  (q_valid),
        .beat_ready  (q_ready),
        .beat        (q_beat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule
